### hw/rtl/wpsp_pkg.sv
`default_nettype none

package wpsp_pkg;

  // Largest accepted file and the smallest possible header-complete file
  localparam int unsigned MaxFileBytes = 67108864;
  localparam int unsigned PosWidth     = $clog2(MaxFileBytes + 2);
  localparam logic [PosWidth-1:0] MAX_FILE_BYTES = PosWidth'(MaxFileBytes);
  localparam logic [PosWidth-1:0] MIN_FILE_BYTES = PosWidth'(44);
  localparam logic [PosWidth-1:0] FILE_HDR_BYTES = PosWidth'(12);

  // Tags, little-endian as they arrive
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] RATE_RESET = 32'd16000;

  localparam int unsigned CountWidth = 26;
  localparam logic [CountWidth-1:0] SAMPLE_CAP = {CountWidth{1'b1}};

  // Bytes of the fmt chunk held for the shape check (the last one is checked live)
  localparam int unsigned FmtStoreDepth = 15;
  localparam logic [31:0] FMT_CHECK_OFF = 32'd15;

  // Verdict codes
  localparam logic [3:0] VERDICT_OK        = 4'd0;
  localparam logic [3:0] VERDICT_SIZE      = 4'd1;
  localparam logic [3:0] VERDICT_TAGS      = 4'd2;
  localparam logic [3:0] VERDICT_RIFF_SIZE = 4'd3;
  localparam logic [3:0] VERDICT_OVERRUN   = 4'd4;
  localparam logic [3:0] VERDICT_FMT_DUP   = 4'd5;
  localparam logic [3:0] VERDICT_FMT_SHAPE = 4'd6;
  localparam logic [3:0] VERDICT_DATA_BAD  = 4'd7;
  localparam logic [3:0] VERDICT_MISSING   = 4'd8;

  // Result kinds
  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Output queue
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrWidth  = $clog2(QueueDepth);
  localparam int unsigned QCntWidth  = $clog2(QueueDepth + 1);

  // Chunk walk phase
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_PAD     = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic                   result_kind;
    logic signed [15:0]     pcm_sample;
    logic [3:0]             verdict;
    logic [CountWidth-1:0]  samples_seen;
    logic                   last_result;
  } result_t;

  // Up to two results per byte: a sample, then the verdict
  typedef struct packed {
    logic    sample_vld;
    logic    verdict_vld;
    result_t sample;
    result_t verdict;
  } push_t;

endpackage

`default_nettype wire

### hw/rtl/wpsp_parse.sv
`default_nettype none

module wpsp_parse
  import wpsp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        go_i,
  input  wire in_item_t    item_i,
  output push_t            push_o
);

  logic [31:0]          rate_q;
  logic [PosWidth-1:0]  pos_q, pos_d;
  logic [31:0]          decl_len_q, decl_len_d;
  logic                 tag_bad_q, tag_bad_d;
  phase_e               phase_q, phase_d;
  logic [31:0]          chunk_tag_q, chunk_tag_d;
  logic [31:0]          chunk_len_q, chunk_len_d;
  logic [31:0]          left_q, left_d;
  logic [2:0]           hdr_idx_q, hdr_idx_d;
  logic                 fmt_found_q, fmt_found_d;
  logic                 data_found_q, data_found_d;
  logic [3:0]           pend_err_q, pend_err_d;
  logic [3:0]           comm_err_q, comm_err_d;
  logic [7:0]           low_byte_q, low_byte_d;
  logic [CountWidth-1:0] total_q, total_d;
  logic [7:0]           fmt_store_q [FmtStoreDepth];

  logic [7:0]  b;
  logic [31:0] off;
  logic [31:0] full_len;
  logic [31:0] left_dec;
  logic        fmt_wr;
  logic        fmt_bad;
  logic        finish;
  logic [3:0]  verdict;
  logic [PosWidth:0] riff_plus;

  assign b        = item_i.byte_value;
  assign off      = chunk_len_q - left_q;
  assign full_len = {b, chunk_len_q[23:0]};
  assign left_dec = left_q - 32'd1;

  // fmt shape: byte 15 is the current byte
  assign fmt_bad = ({fmt_store_q[1], fmt_store_q[0]} != 16'd1) ||
                   ({fmt_store_q[3], fmt_store_q[2]} != 16'd1) ||
                   ({fmt_store_q[7], fmt_store_q[6], fmt_store_q[5], fmt_store_q[4]}
                    != rate_q) ||
                   ({fmt_store_q[13], fmt_store_q[12]} != 16'd2) ||
                   ({b, fmt_store_q[14]} != 16'd16);

  // Byte walk
  always_comb begin
    pos_d        = pos_q;
    decl_len_d   = decl_len_q;
    tag_bad_d    = tag_bad_q;
    phase_d      = phase_q;
    chunk_tag_d  = chunk_tag_q;
    chunk_len_d  = chunk_len_q;
    left_d       = left_q;
    hdr_idx_d    = hdr_idx_q;
    fmt_found_d  = fmt_found_q;
    data_found_d = data_found_q;
    pend_err_d   = pend_err_q;
    comm_err_d   = comm_err_q;
    low_byte_d   = low_byte_q;
    total_d      = total_q;
    fmt_wr       = 1'b0;
    finish       = 1'b0;
    push_o       = '0;
    push_o.sample.result_kind  = KIND_SAMPLE;
    push_o.verdict.result_kind = KIND_VERDICT;
    push_o.verdict.last_result = 1'b1;

    if (pos_q < FILE_HDR_BYTES) begin
      // File header: tags and RIFF size
      if (pos_q < PosWidth'(4)) begin
        if (b != TAG_RIFF[{pos_q[1:0], 3'b000} +: 8]) tag_bad_d = 1'b1;
      end else if (pos_q < PosWidth'(8)) begin
        decl_len_d[{pos_q[1:0], 3'b000} +: 8] = b;
      end else if (b != TAG_WAVE[{pos_q[1:0], 3'b000} +: 8]) begin
        tag_bad_d = 1'b1;
      end
    end else begin
      unique case (phase_q)
        PH_HEADER: begin
          if (!hdr_idx_q[2]) begin
            chunk_tag_d[{hdr_idx_q[1:0], 3'b000} +: 8] = b;
          end else begin
            chunk_len_d[{hdr_idx_q[1:0], 3'b000} +: 8] = b;
          end
          hdr_idx_d = hdr_idx_q + 3'd1;
          if (hdr_idx_q == 3'd7) begin
            // Open the chunk
            pend_err_d = VERDICT_OK;
            if (chunk_tag_q == TAG_FMT) begin
              if (fmt_found_q || (full_len < 32'd16)) pend_err_d = VERDICT_FMT_DUP;
              else fmt_found_d = 1'b1;
            end else if (chunk_tag_q == TAG_DATA) begin
              if (data_found_q || (full_len == 32'd0) || full_len[0]) begin
                pend_err_d = VERDICT_DATA_BAD;
              end else begin
                data_found_d = 1'b1;
              end
            end
            chunk_len_d = full_len;
            left_d      = full_len;
            phase_d     = PH_PAYLOAD;
            finish      = (full_len == 32'd0);
          end
        end
        PH_PAYLOAD: begin
          if ((chunk_tag_q == TAG_FMT) && (pend_err_q == VERDICT_OK) && (off < 32'd16)) begin
            fmt_wr = (off != FMT_CHECK_OFF);
            if ((off == FMT_CHECK_OFF) && fmt_bad) pend_err_d = VERDICT_FMT_SHAPE;
          end else if ((chunk_tag_q == TAG_DATA) && (pend_err_q == VERDICT_OK)) begin
            if (off[0]) begin
              push_o.sample_vld        = 1'b1;
              push_o.sample.pcm_sample = {b, low_byte_q};
              if (total_q != SAMPLE_CAP) total_d = total_q + CountWidth'(1);
            end else begin
              low_byte_d = b;
            end
          end
          left_d = left_dec;
          finish = (left_dec == 32'd0);
        end
        PH_PAD: begin
          phase_d = PH_HEADER;
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
    end

    // Close the chunk
    if (finish) begin
      if (comm_err_q == VERDICT_OK) comm_err_d = pend_err_d;
      phase_d     = chunk_len_d[0] ? PH_PAD : PH_HEADER;
      chunk_tag_d = '0;
      chunk_len_d = '0;
      left_d      = '0;
      pend_err_d  = VERDICT_OK;
    end

    if (pos_q <= MAX_FILE_BYTES) pos_d = pos_q + PosWidth'(1);

    // Verdict
    riff_plus = {1'b0, decl_len_d[PosWidth-1:0]} + (PosWidth+1)'(8);
    if ((pos_d < MIN_FILE_BYTES) || (pos_d > MAX_FILE_BYTES)) begin
      verdict = VERDICT_SIZE;
    end else if (tag_bad_d) begin
      verdict = VERDICT_TAGS;
    end else if ((decl_len_d[31:PosWidth] != '0) || (riff_plus > {1'b0, pos_d})) begin
      verdict = VERDICT_RIFF_SIZE;
    end else if (comm_err_d != VERDICT_OK) begin
      verdict = comm_err_d;
    end else if (phase_d == PH_PAYLOAD) begin
      verdict = VERDICT_OVERRUN;
    end else if (!fmt_found_d || !data_found_d) begin
      verdict = VERDICT_MISSING;
    end else begin
      verdict = VERDICT_OK;
    end
    push_o.verdict.verdict      = verdict;
    push_o.verdict.samples_seen = total_d;
    push_o.verdict_vld          = item_i.final_byte;

    // New file after the verdict
    if (item_i.final_byte) begin
      pos_d        = '0;
      decl_len_d   = '0;
      tag_bad_d    = 1'b0;
      phase_d      = PH_HEADER;
      chunk_tag_d  = '0;
      chunk_len_d  = '0;
      left_d       = '0;
      hdr_idx_d    = '0;
      fmt_found_d  = 1'b0;
      data_found_d = 1'b0;
      pend_err_d   = VERDICT_OK;
      comm_err_d   = VERDICT_OK;
      low_byte_d   = '0;
      total_d      = '0;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else if (cfg_we_i) begin
      rate_q <= cfg_wdata_i;
    end
  end

  // File state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      decl_len_q   <= '0;
      tag_bad_q    <= 1'b0;
      phase_q      <= PH_HEADER;
      chunk_tag_q  <= '0;
      chunk_len_q  <= '0;
      left_q       <= '0;
      hdr_idx_q    <= '0;
      fmt_found_q  <= 1'b0;
      data_found_q <= 1'b0;
      pend_err_q   <= VERDICT_OK;
      comm_err_q   <= VERDICT_OK;
      low_byte_q   <= '0;
      total_q      <= '0;
    end else if (go_i) begin
      pos_q        <= pos_d;
      decl_len_q   <= decl_len_d;
      tag_bad_q    <= tag_bad_d;
      phase_q      <= phase_d;
      chunk_tag_q  <= chunk_tag_d;
      chunk_len_q  <= chunk_len_d;
      left_q       <= left_d;
      hdr_idx_q    <= hdr_idx_d;
      fmt_found_q  <= fmt_found_d;
      data_found_q <= data_found_d;
      pend_err_q   <= pend_err_d;
      comm_err_q   <= comm_err_d;
      low_byte_q   <= low_byte_d;
      total_q      <= total_d;
    end
  end

  // fmt bytes, no reset: read only once written for the current chunk
  always_ff @(posedge clk_i) begin
    if (go_i && fmt_wr) begin
      fmt_store_q[off[3:0]] <= b;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/wpsp_out_queue.sv
`default_nettype none

module wpsp_out_queue
  import wpsp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_en_i,
  input  wire push_t   push_i,
  output logic         room_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      out_data_o
);

  result_t              mem_q [QueueDepth];
  logic [QPtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntWidth-1:0] cnt_q;
  logic                 pop;
  logic                 wr0, wr1;
  logic [QPtrWidth-1:0] wr1_ptr;
  logic [QCntWidth-1:0] n_push;

  assign wr0     = push_en_i && push_i.sample_vld;
  assign wr1     = push_en_i && push_i.verdict_vld;
  assign wr1_ptr = wr_ptr_q + QPtrWidth'(wr0);
  assign n_push  = QCntWidth'(wr0) + QCntWidth'(wr1);

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  // Space for the worst case of two results
  assign room_o      = (cnt_q <= QCntWidth'(QueueDepth - 2));

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrWidth'(n_push);
      rd_ptr_q <= rd_ptr_q + QPtrWidth'(pop);
      cnt_q    <= cnt_q + n_push - QCntWidth'(pop);
    end
  end

  // Entries, sample before verdict
  always_ff @(posedge clk_i) begin
    if (wr0) mem_q[wr_ptr_q] <= push_i.sample;
    if (wr1) mem_q[wr1_ptr]  <= push_i.verdict;
  end

endmodule

`default_nettype wire

### hw/rtl/wav_pcm16_stream_parser.sv
`default_nettype none

// Byte-stream parser for RIFF/WAVE files holding mono 16-bit PCM. One file byte
// is taken per clock unless input stalls; the byte is registered, then parsed
// and its results queued, so one byte per cycle is sustained while the queue has
// room. A byte gives at most one sample result (on the high byte of each sample
// of the accepted data chunk), and the byte marked final adds a verdict result
// after it. The output queue holds four results and drains one per cycle, so
// input stalls only when the queue cannot take two more, which happens only while
// the consumer stalls. Samples are sent even for files that later fail; discard
// them unless the verdict is 0. Write the expected sample rate only while idle.
module wav_pcm16_stream_parser
  import wpsp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output result_t          out_data_o
);

  logic     in_valid_q;
  in_item_t in_data_q;
  logic     room;
  logic     go;
  push_t    push;

  assign go         = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  wpsp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .go_i        (go),
    .item_i      (in_data_q),
    .push_o      (push)
  );

  wpsp_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_en_i   (go),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
